### src/sstis_pkg.sv
// Shared types and codes for the sorted string table insert and search unit.
package sstis_pkg;

    typedef struct packed {
        logic       command;
        logic       part;
        logic [7:0] character;
        logic       last_char;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] entry_index;
        logic [7:0] character_res;
        logic       last_result;
    } response_t;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;
    localparam logic PART_KEY   = 1'b0;
    localparam logic PART_VALUE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_WAIT,
        S_INS_CMP,
        S_SHIFT,
        S_SH_WAIT,
        S_SH_WR,
        S_INS_WR,
        S_FULL,
        S_LK_CHK,
        S_LK_WAIT,
        S_LK_CMP,
        S_LK_OUT,
        S_NOT_FOUND
    } state_t;

endpackage

### src/sstis_store.sv
// Key and value row memories: one write and one registered read per cycle.
module sstis_store #(
    parameter int ENTRIES    = 64,
    parameter int WORD_CHARS = 19,
    localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                       clk,
    input  logic [AW-1:0]              rd_addr,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [WORD_CHARS-1:0][7:0] wr_key,
    input  logic [WORD_CHARS-1:0][7:0] wr_val,
    output logic [WORD_CHARS-1:0][7:0] rd_key,
    output logic [WORD_CHARS-1:0][7:0] rd_val
);

    logic [WORD_CHARS-1:0][7:0] key_mem [ENTRIES];
    logic [WORD_CHARS-1:0][7:0] val_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key <= key_mem[rd_addr];
        rd_val <= val_mem[rd_addr];
    end

endmodule

### src/sorted_string_table_insert_search_unit.sv
// Sorted key/value string table: input assembly, insert sequencer and binary search.
// Strings are taken one character per cycle while idle. An insert scans entries
// linearly from the first, then moves each later entry up one row.
// A lookup is a binary search of at most floor(log2(ENTRIES))+1 probes, then emits
// one value character per cycle while the response is not stalled.
// Reset clears the entry count, buffers and control; the memories are not cleared.
module sorted_string_table_insert_search_unit #(
    parameter int ENTRIES    = 64,
    parameter int WORD_CHARS = 19
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sstis_pkg::request_t request,
    input  logic                request_valid,
    output logic                request_stall,
    output sstis_pkg::response_t response,
    output logic                response_valid,
    input  logic                response_stall
);

    import sstis_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW = $clog2(ENTRIES + 1);
    localparam int XW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
    localparam int CW = $clog2(WORD_CHARS + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [XW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] count_reg, count_next;
    logic signed [NW:0] lo_reg, lo_next;
    logic signed [NW:0] hi_reg, hi_next;
    logic [WORD_CHARS-1:0][7:0] key_buf_reg, key_buf_next;
    logic [WORD_CHARS-1:0][7:0] val_buf_reg, val_buf_next;
    logic out_valid_reg, out_valid_next;
    response_t out_reg, out_next;

    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [WORD_CHARS-1:0][7:0] wr_key, wr_val, rd_key, rd_val;
    logic can_emit;
    logic [7:0] byte_a, byte_b;
    logic signed [NW+1:0] mid_sum;
    logic last_char_out;

    sstis_store #(
        .ENTRIES   (ENTRIES),
        .WORD_CHARS(WORD_CHARS)
    ) u_store (
        .clk    (clk),
        .rd_addr(ptr_reg),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_key (wr_key),
        .wr_val (wr_val),
        .rd_key (rd_key),
        .rd_val (rd_val)
    );

    assign request_stall  = (state_reg != S_IDLE);
    assign response_valid = out_valid_reg;
    assign response       = out_reg;
    assign can_emit       = !out_valid_reg || !response_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            key_buf_reg   <= '0;
            val_buf_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            key_buf_reg   <= key_buf_next;
            val_buf_reg   <= val_buf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_buf_next   = key_buf_reg;
        val_buf_next   = val_buf_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_key         = rd_key;
        wr_val         = rd_val;
        byte_a         = 8'd0;
        byte_b         = 8'd0;
        mid_sum        = (NW+2)'(lo_reg) + (NW+2)'(hi_reg);
        last_char_out  = 1'b1;

        if (out_valid_reg && !response_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (request_valid &&
                    !(request.command == CMD_LOOKUP && request.part == PART_VALUE))
                begin
                    if (request.part == PART_VALUE)
                    begin
                        if (pos_reg == '0)
                        begin
                            val_buf_next = '0;
                        end
                        if (pos_reg < CW'(WORD_CHARS))
                        begin
                            val_buf_next[pos_reg[XW-1:0]] = request.character;
                        end
                    end
                    else
                    begin
                        if (pos_reg == '0)
                        begin
                            key_buf_next = '0;
                        end
                        if (pos_reg < CW'(WORD_CHARS))
                        begin
                            key_buf_next[pos_reg[XW-1:0]] = request.character;
                        end
                    end
                    if (pos_reg < CW'(WORD_CHARS))
                    begin
                        pos_next = pos_reg + CW'(1);
                    end
                    if (request.last_char)
                    begin
                        pos_next = '0;
                        if (request.command == CMD_LOOKUP)
                        begin
                            lo_next    = '0;
                            hi_next    = $signed((NW+1)'(count_reg)) - (NW+1)'(1);
                            state_next = S_LK_CHK;
                        end
                        else if (request.part == PART_VALUE)
                        begin
                            k_next = '0;
                            if (count_reg >= NW'(ENTRIES))
                            begin
                                state_next = S_FULL;
                            end
                            else
                            begin
                                state_next = S_INS_SCAN;
                            end
                        end
                    end
                end
            end

            S_INS_SCAN:
            begin
                if (k_reg == count_reg)
                begin
                    i_next     = count_reg;
                    state_next = S_SHIFT;
                end
                else
                begin
                    ptr_next   = k_reg[AW-1:0];
                    cnt_next   = '0;
                    state_next = S_INS_WAIT;
                end
            end

            S_INS_WAIT:
            begin
                state_next = S_INS_CMP;
            end

            S_INS_CMP:
            begin
                byte_a = rd_key[cnt_reg];
                byte_b = key_buf_reg[cnt_reg];
                if (byte_a != byte_b)
                begin
                    if (byte_a < byte_b)
                    begin
                        k_next     = k_reg + NW'(1);
                        state_next = S_INS_SCAN;
                    end
                    else
                    begin
                        i_next     = count_reg;
                        state_next = S_SHIFT;
                    end
                end
                else if (byte_a == 8'd0 || cnt_reg == XW'(WORD_CHARS - 1))
                begin
                    i_next     = count_reg;
                    state_next = S_SHIFT;
                end
                else
                begin
                    cnt_next = cnt_reg + XW'(1);
                end
            end

            S_SHIFT:
            begin
                if (i_reg == k_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    ptr_next   = AW'(i_reg - NW'(1));
                    state_next = S_SH_WAIT;
                end
            end

            S_SH_WAIT:
            begin
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[AW-1:0];
                i_next     = i_reg - NW'(1);
                state_next = S_SHIFT;
            end

            S_INS_WR:
            begin
                if (can_emit)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = k_reg[AW-1:0];
                    wr_key         = key_buf_reg;
                    wr_val         = val_buf_reg;
                    count_next     = count_reg + NW'(1);
                    out_valid_next = 1'b1;
                    out_next       = '{ST_INSERTED, 6'(k_reg[AW-1:0]), 8'd0, 1'b1};
                    key_buf_next   = '0;
                    val_buf_next   = '0;
                    state_next     = S_IDLE;
                end
            end

            S_FULL:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{ST_FULL, 6'd0, 8'd0, 1'b1};
                    key_buf_next   = '0;
                    val_buf_next   = '0;
                    state_next     = S_IDLE;
                end
            end

            S_LK_CHK:
            begin
                if (lo_reg > hi_reg)
                begin
                    state_next = S_NOT_FOUND;
                end
                else
                begin
                    ptr_next   = AW'(mid_sum >>> 1);
                    cnt_next   = '0;
                    state_next = S_LK_WAIT;
                end
            end

            S_LK_WAIT:
            begin
                state_next = S_LK_CMP;
            end

            S_LK_CMP:
            begin
                byte_a = key_buf_reg[cnt_reg];
                byte_b = rd_key[cnt_reg];
                if (byte_a != byte_b)
                begin
                    if (byte_a < byte_b)
                    begin
                        hi_next = $signed((NW+1)'(ptr_reg)) - (NW+1)'(1);
                    end
                    else
                    begin
                        lo_next = $signed((NW+1)'(ptr_reg)) + (NW+1)'(1);
                    end
                    state_next = S_LK_CHK;
                end
                else if (byte_a == 8'd0 || cnt_reg == XW'(WORD_CHARS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_LK_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + XW'(1);
                end
            end

            S_LK_OUT:
            begin
                // The value ends at its first zero byte or at the slot width.
                if (cnt_reg != XW'(WORD_CHARS - 1))
                begin
                    last_char_out = (rd_val[XW'(cnt_reg + XW'(1))] == 8'd0);
                end
                if (rd_val[cnt_reg] == 8'd0)
                begin
                    last_char_out = 1'b1;
                end
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{ST_FOUND, 6'(ptr_reg), rd_val[cnt_reg], last_char_out};
                    if (last_char_out)
                    begin
                        key_buf_next = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + XW'(1);
                    end
                end
            end

            S_NOT_FOUND:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{ST_NOT_FOUND, 6'd0, 8'd0, 1'b1};
                    key_buf_next   = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
